### hdl/mpeg_picture_unit_splitter_core_defines.svh
// Assertion macros for the picture unit splitter RTL.
`ifndef MPEG_PICTURE_UNIT_SPLITTER_CORE_DEFINES_SVH
`define MPEG_PICTURE_UNIT_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MPUS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MPUS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mpus_pkg.sv
// Package: types and constants of the MPEG picture unit splitter.
`default_nettype none
package mpus_pkg;

    localparam int LEN_BITS = 21;
    localparam longint LEN_LIMIT = (longint'(1) << LEN_BITS) - 1;
    localparam longint DEFAULT_MAX = 65536;
    localparam logic [LEN_BITS-1:0] MAX_RESET =
        (DEFAULT_MAX > LEN_LIMIT) ? '1 : LEN_BITS'(DEFAULT_MAX);

    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = BYTE_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = ((BYTE_W + LEN_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // step positions inside one command, executed lowest first
    localparam int STEP_CLOSE  = 0;
    localparam int STEP_ZERO_A = 1;
    localparam int STEP_ZERO_B = 2;
    localparam int STEP_ONE    = 3;
    localparam int STEP_BYTE   = 4;
    localparam int NUM_STEPS   = 5;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_EOS  = 1'b1
    } t_req;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    typedef logic [NUM_STEPS-1:0] t_step_mask;

    typedef struct packed {
        t_step_mask        steps;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data;
        logic                first;
        logic [LEN_BITS-1:0] len;
        logic                trunc;
        logic                last;
    } t_result;

endpackage
`default_nettype wire

### hdl/mpus_front.sv
// Front end: start code tracking, turns input words into step commands.
`default_nettype none
module mpus_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [mpus_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  wire logic [mpus_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    input  wire mpus_pkg::t_q_status              i_q_stat,
    output logic                                  o_push,
    output mpus_pkg::t_cmd                        o_cmd
);
    import mpus_pkg::*;

    localparam logic [1:0] HELD_MAX = 2'd2;

    logic [1:0]        r_held, n_held;
    logic              r_pend, n_pend;
    logic              accept;
    t_req              req;
    logic [BYTE_W-1:0] in_b;

    assign o_s_axis_tready = !i_q_stat.full;
    assign accept = i_s_axis_tvalid && !i_q_stat.full;
    assign req    = t_req'(i_s_axis_tuser[0]);
    assign in_b   = i_s_axis_tdata[BYTE_W-1:0];

    always_comb begin
        n_held = r_held;
        n_pend = r_pend;
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            priority if (req == REQ_EOS) begin
                o_cmd.steps[STEP_CLOSE] = 1'b1;
                o_push = 1'b1;
                n_held = '0;
                n_pend = 1'b0;
            end else if (in_b == '0) begin
                priority if (r_pend) begin
                    // picture start code: close unit, reopen with 00 00 01 00
                    o_cmd.steps = '1;
                    o_push = 1'b1;
                    n_held = '0;
                    n_pend = 1'b0;
                end else if (r_held == HELD_MAX) begin
                    o_cmd.steps[STEP_BYTE] = 1'b1;
                    o_push = 1'b1;
                end else begin
                    n_held = r_held + 2'd1;
                end
            end else if (!r_pend && in_b == BYTE_W'(1) && r_held == HELD_MAX) begin
                n_pend = 1'b1;
            end else begin
                o_cmd.steps[STEP_ZERO_A] = (r_held != '0);
                o_cmd.steps[STEP_ZERO_B] = (r_held == HELD_MAX);
                o_cmd.steps[STEP_ONE]    = r_pend;
                o_cmd.steps[STEP_BYTE]   = 1'b1;
                o_cmd.data = in_b;
                o_push = 1'b1;
                n_held = '0;
                n_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pend <= 1'b0;
        end else begin
            r_held <= n_held;
            r_pend <= n_pend;
        end
    end

endmodule
`default_nettype wire

### hdl/mpus_queue.sv
// Command queue between front and back end.
`default_nettype none
module mpus_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mpus_pkg::t_cmd   i_cmd,
    input  wire logic             i_pop,
    output mpus_pkg::t_cmd        o_head,
    output mpus_pkg::t_q_status   o_stat
);
    import mpus_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_stat.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + QUEUE_AW'(1) : r_wr;
        n_rd  = do_pop ? r_rd + QUEUE_AW'(1) : r_rd;
        n_cnt = r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/mpus_back.sv
// Back end: runs command steps, keeps unit length and limit, drives result register.
`default_nettype none
`include "mpeg_picture_unit_splitter_core_defines.svh"
module mpus_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [mpus_pkg::LEN_BITS-1:0]   i_cfg_data,
    input  wire mpus_pkg::t_cmd                  i_head,
    input  wire mpus_pkg::t_q_status             i_q_stat,
    output logic                                 o_pop,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output mpus_pkg::t_result                    o_res
);
    import mpus_pkg::*;

    logic [LEN_BITS-1:0] r_max, n_max;
    logic [LEN_BITS-1:0] r_count, n_count;
    logic                r_dropped, n_dropped;
    logic                r_at_start, n_at_start;
    t_step_mask          r_taken, n_taken;
    logic                r_ovalid, n_ovalid;
    t_result             r_res, n_res;
    logic                load;

    logic                slot, go, finish;
    t_step_mask          cur, low, rest;
    logic [LEN_BITS:0]   cnt_inc;
    logic                full_now, full_after, max_zero;
    logic [BYTE_W-1:0]   step_byte;

    always_comb begin
        slot       = !r_ovalid || i_out_ready;
        go         = !i_q_stat.empty && slot;
        cur        = i_head.steps & ~r_taken;
        low        = cur & (~cur + NUM_STEPS'(1));
        rest       = cur & ~low;
        cnt_inc    = {1'b0, r_count} + (LEN_BITS+1)'(1);
        full_now   = (r_count >= r_max);
        full_after = (cnt_inc >= {1'b0, r_max});
        max_zero   = (r_max == '0);
        priority if (low[STEP_BYTE]) begin
            step_byte = i_head.data;
        end else if (low[STEP_ONE]) begin
            step_byte = BYTE_W'(1);
        end else begin
            step_byte = '0;
        end
    end

    always_comb begin
        n_max      = i_cfg_valid ? i_cfg_data : r_max;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_at_start = r_at_start;
        n_taken    = r_taken;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_res      = r_res;
        load       = 1'b0;
        finish     = 1'b0;
        o_pop      = 1'b0;
        if (go) begin
            priority if (low[STEP_CLOSE]) begin
                load        = 1'b1;
                n_res.kind  = KIND_END;
                n_res.data  = '0;
                n_res.first = 1'b0;
                n_res.len   = r_count;
                n_res.trunc = r_dropped;
                n_res.last  = (rest == '0) || max_zero;
                n_count     = '0;
                n_at_start  = 1'b1;
                n_dropped   = (rest != '0) && max_zero;
                finish      = n_res.last;
            end else if (full_now) begin
                // unit full: every remaining step is a data byte, drop them all
                n_dropped = 1'b1;
                finish    = 1'b1;
            end else begin
                load        = 1'b1;
                n_res.kind  = KIND_DATA;
                n_res.data  = step_byte;
                n_res.first = r_at_start;
                n_res.len   = '0;
                n_res.trunc = 1'b0;
                n_res.last  = (rest == '0) || full_after;
                n_at_start  = 1'b0;
                n_count     = cnt_inc[LEN_BITS-1:0];
                if ((rest != '0) && full_after) begin
                    n_dropped = 1'b1;
                end
                finish = n_res.last;
            end
            if (load) begin
                n_ovalid = 1'b1;
            end
            if (finish) begin
                o_pop   = 1'b1;
                n_taken = '0;
            end else begin
                n_taken = r_taken | low;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= MAX_RESET;
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_at_start <= 1'b1;
            r_taken    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_max      <= n_max;
            r_count    <= n_count;
            r_dropped  <= n_dropped;
            r_at_start <= n_at_start;
            r_taken    <= n_taken;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    `MPUS_ASSERT_IMP(a_taken_in_head, !i_q_stat.empty, (r_taken & ~i_head.steps) == '0, "taken steps outside head command")
    `MPUS_ASSERT_IMP(a_taken_needs_cmd, r_taken != '0, !i_q_stat.empty, "partial command with empty queue")
    `MPUS_ASSERT_NXT(a_count_step, go && !low[STEP_CLOSE] && !full_now, r_count == $past(r_count) + LEN_BITS'(1), "unit length did not advance on kept byte")

endmodule
`default_nettype wire

### hdl/mpeg_picture_unit_splitter_core.sv
// Top level: MPEG picture unit splitter, front end, command queue and back end.
`default_nettype none
// Splits an MPEG video byte stream into units that start at each picture
// start code 00 00 01 00. The front end takes one input word per cycle while
// the four-entry command queue has room; it holds up to two zeros and a
// pending 00 00 01 and issues one command per word that yields output. The
// back end runs one command step per cycle into the output register while the
// output is taken, so a word yields k results (k from 1 to 5), one per step;
// a run of bytes dropped at the unit limit gives no word. Ordinary data thus
// sustains one word per cycle; longer bursts are absorbed by the queue. tlast
// marks the last result word caused by one input word. The user must write the
// max_unit_bytes register through the cfg port only while idle; not enforced.
module mpeg_picture_unit_splitter_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mpus_pkg::LEN_BITS-1:0]    i_cfg_data,     // max_unit_bytes
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [mpus_pkg::IN_DATA_W-1:0]   i_s_axis_tdata, // in_byte
    input  wire logic [mpus_pkg::IN_USER_W-1:0]   i_s_axis_tuser, // req_type
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // out_byte[7:0], unit_length[28:8], truncated[29], zero pad
    output logic [mpus_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic [mpus_pkg::OUT_USER_W-1:0]       o_m_axis_tuser, // out_kind, first_of_unit
    output logic                                  o_m_axis_tlast  // last_of_run
);
    import mpus_pkg::*;

    t_q_status q_stat;
    t_cmd      push_cmd;
    t_cmd      head;
    logic      push;
    logic      pop;
    t_result   res;

    assign o_cfg_ready = 1'b1;

    mpus_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    mpus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    mpus_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_res       (res)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({res.trunc, res.len, res.data});
    assign o_m_axis_tuser = {res.first, res.kind};
    assign o_m_axis_tlast = res.last;

endmodule
`default_nettype wire
